/* hw/rtl/gdn_pkg.sv */
// Package: shared types, constants and date helper functions for the day number unit.
`timescale 1ns / 1ps
`default_nettype none
package gdn_pkg;

   localparam int unsigned QueueDepth = 2;

   typedef enum logic [2:0] {
      ACT_TO_JDN   = 3'd0,
      ACT_ADD      = 3'd1,
      ACT_SUB      = 3'd2,
      ACT_WEEKDAY  = 3'd3,
      ACT_DIFF     = 3'd4,
      ACT_FROM_JDN = 3'd5,
      ACT_RSVD6    = 3'd6,
      ACT_RSVD7    = 3'd7
   } action_type;

   localparam logic [22:0] JdnMin = 23'd1721426;
   localparam logic [22:0] JdnMax = 23'd5373484;

   // Classified item handed from front to back.
   typedef struct packed {
      logic               ok;
      action_type         action;
      logic signed [24:0] jdn;
      logic        [22:0] num;
   } work_type;

   // Quotient by 100 for 15-bit values: multiply by 2^19/100 rounded up.
   function automatic logic [7:0] div100(input logic [14:0] x);
      logic [27:0] p;
      p      = 28'(x) * 28'd5243;
      div100 = 8'(p >> 19);
   endfunction

   // Year leap test; divisible by 400 means century remainder zero and century count mod 4 zero.
   function automatic logic is_leap(input logic [13:0] y);
      logic [7:0]  q100;
      logic [14:0] r100;
      q100    = div100(15'(y));
      r100    = 15'(y) - 15'(q100) * 15'd100;
      is_leap = (y[1:0] == 2'b00) && ((r100 != 15'd0) || (q100[1:0] == 2'b00));
   endfunction

   function automatic logic date_valid(input logic [4:0] d, input logic [3:0] m,
                                       input logic [13:0] y);
      logic [4:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                       len = is_leap(y) ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      date_valid = (y >= 14'd1) && (y <= 14'd9999) && (d >= 5'd1) && (d <= len);
   endfunction

   // Gregorian date to Julian day number; date assumed valid.
   function automatic logic [22:0] date_to_jdn(input logic [4:0] d, input logic [3:0] m,
                                                 input logic [13:0] y);
      logic        a;
      logic [14:0] yy;
      logic [3:0]  mm;
      logic [8:0]  mterm;
      logic [7:0]  c100;
      logic [23:0] sum;
      a  = (m <= 4'd2);
      yy = 15'(y) + 15'd4800 - 15'(a);
      mm = a ? (m + 4'd9) : (m - 4'd3);
      // days before the month in a March-based year
      case (mm)
         4'd0:    mterm = 9'd0;
         4'd1:    mterm = 9'd31;
         4'd2:    mterm = 9'd61;
         4'd3:    mterm = 9'd92;
         4'd4:    mterm = 9'd122;
         4'd5:    mterm = 9'd153;
         4'd6:    mterm = 9'd184;
         4'd7:    mterm = 9'd214;
         4'd8:    mterm = 9'd245;
         4'd9:    mterm = 9'd275;
         4'd10:   mterm = 9'd306;
         4'd11:   mterm = 9'd337;
         default: mterm = 9'd0;
      endcase
      c100 = div100(yy);
      sum  = 24'(d) + 24'(mterm) + 24'(yy) * 24'd365 + 24'(yy >> 2)
             - 24'(c100) + 24'(c100 >> 2) - 24'd32045;
      date_to_jdn = sum[22:0];
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/gregorian_day_number_unit.sv */
// Top level: Gregorian date arithmetic unit, front checker, queue and date back end.
//
//   channel | ports         | direction | beat
//   req     | req_*         | in        | one action with its dates and numbers
//   rsp     | rsp_*         | out       | one date, number, weekday and ok flag
//
// One beat per cycle sustained; a beat taken at a rising edge reaches rsp_valid through
// two front steps, one queue entry and three back end steps, each registered. Every step
// takes a new beat each cycle, so only rsp_stall lowers the rate. Reset clears all
// valid bits and queue pointers synchronously. rsp_stall holds the back end; the
// two-entry queue and both front steps then fill and req_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module gregorian_day_number_unit #(
   parameter int unsigned QueueDepth = gdn_pkg::QueueDepth
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_action,
   input  wire logic [4:0]         req_day,
   input  wire logic [3:0]         req_month,
   input  wire logic [13:0]        req_year,
   input  wire logic signed [22:0] req_offset_days,
   input  wire logic [22:0]        req_day_number_in,
   input  wire logic [4:0]         req_other_day,
   input  wire logic [3:0]         req_other_month,
   input  wire logic [13:0]        req_other_year,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [4:0]              rsp_out_day,
   output logic [3:0]              rsp_out_month,
   output logic [13:0]             rsp_out_year,
   output logic [22:0]             rsp_number_out,
   output logic [2:0]              rsp_weekday,
   output logic                    rsp_ok
);
   logic              fq_valid, fq_stall, qb_valid, qb_stall;
   gdn_pkg::work_type fq_work, qb_work;

   // Classify and compute the day number of each beat.
   gdn_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall),
      .action(req_action), .day(req_day), .month(req_month), .year(req_year),
      .offset_days(req_offset_days), .day_number_in(req_day_number_in),
      .other_day(req_other_day), .other_month(req_other_month),
      .other_year(req_other_year),
      .out_valid(fq_valid), .out_stall(fq_stall), .out_work(fq_work)
   );

   // Decouple front from back.
   gdn_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset,
      .in_valid(fq_valid), .in_stall(fq_stall), .in_work(fq_work),
      .out_valid(qb_valid), .out_stall(qb_stall), .out_work(qb_work)
   );

   // Convert back to a calendar date.
   gdn_back u_back (
      .clock, .reset,
      .in_valid(qb_valid), .in_stall(qb_stall), .in_work(qb_work),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_day(rsp_out_day), .out_month(rsp_out_month), .out_year(rsp_out_year),
      .number_out(rsp_number_out), .weekday(rsp_weekday), .ok(rsp_ok)
   );

   // A failed beat carries all-zero fields.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_out_day == 5'd0 && rsp_out_year == 14'd0
                                  && rsp_number_out == 23'd0))
      else $error("failed beat with nonzero fields");

   // A good beat has a legal month and weekday.
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ok) |-> (rsp_out_month >= 4'd1 && rsp_out_month <= 4'd12
                                 && rsp_weekday <= 3'd6))
      else $error("good beat out of range");

   // A stalled output holds.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_number_out)))
      else $error("output changed under stall");
endmodule
`default_nettype wire

/* hw/rtl/gdn_front.sv */
// Front stage: check dates, build the result day number and register it.
`timescale 1ns / 1ps
`default_nettype none
module gdn_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_stall,
   input  wire logic [2:0]            action,
   input  wire logic [4:0]            day,
   input  wire logic [3:0]            month,
   input  wire logic [13:0]           year,
   input  wire logic signed [22:0]    offset_days,
   input  wire logic [22:0]           day_number_in,
   input  wire logic [4:0]            other_day,
   input  wire logic [3:0]            other_month,
   input  wire logic [13:0]           other_year,
   output logic                       out_valid,
   input  wire logic                  out_stall,
   output gdn_pkg::work_type          out_work
);
   logic                a_valid_ff;
   gdn_pkg::action_type a_act_ff;
   logic                a_pv_ff, a_ov_ff;
   logic [22:0]         a_pj_ff, a_oj_ff;
   logic signed [22:0]  a_off_ff;
   logic [22:0]         a_jin_ff;
   logic                pv_in, ov_in;
   logic [22:0]         pj_in, oj_in;
   logic              valid_ff;
   gdn_pkg::work_type work_ff;
   gdn_pkg::work_type work_in;
   gdn_pkg::action_type act;
   logic              adv_a, adv_b;
   logic signed [24:0] res;

   assign act = gdn_pkg::action_type'(action);

   // Step A: check both dates and convert them to day numbers.
   always_comb begin
      pv_in = gdn_pkg::date_valid(day, month, year);
      ov_in = gdn_pkg::date_valid(other_day, other_month, other_year);
      pj_in = gdn_pkg::date_to_jdn(day, month, year);
      oj_in = gdn_pkg::date_to_jdn(other_day, other_month, other_year);
   end

   // Step B: apply the action and check the result range.
   always_comb begin
      res = 25'(signed'({2'b00, a_pj_ff}));
      work_in.ok     = a_pv_ff;
      work_in.action = a_act_ff;
      work_in.num    = 23'd0;
      case (a_act_ff)
         gdn_pkg::ACT_TO_JDN:   work_in.num = a_pj_ff;
         gdn_pkg::ACT_ADD:      res = res + 25'(a_off_ff);
         gdn_pkg::ACT_SUB:      res = res - 25'(a_off_ff);
         gdn_pkg::ACT_WEEKDAY:  ;
         gdn_pkg::ACT_DIFF: begin
            work_in.ok  = a_pv_ff && a_ov_ff;
            work_in.num = (a_pj_ff >= a_oj_ff) ? (a_pj_ff - a_oj_ff) : (a_oj_ff - a_pj_ff);
         end
         gdn_pkg::ACT_FROM_JDN: begin
            work_in.ok = 1'b1;
            res        = 25'(signed'({2'b00, a_jin_ff}));
         end
         default:               work_in.ok = 1'b0;
      endcase
      if ((res < 25'(signed'({2'b00, gdn_pkg::JdnMin})))
          || (res > 25'(signed'({2'b00, gdn_pkg::JdnMax})))) begin
         work_in.ok = 1'b0;
      end
      work_in.jdn = res;
   end

   assign adv_b    = !(valid_ff && out_stall);
   assign adv_a    = !(a_valid_ff && !adv_b);
   assign in_stall = !adv_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         if (adv_a) a_valid_ff <= in_valid;
         if (adv_b) valid_ff   <= a_valid_ff;
      end
      if (adv_a) begin
         a_act_ff <= act;
         a_pv_ff  <= pv_in;
         a_ov_ff  <= ov_in;
         a_pj_ff  <= pj_in;
         a_oj_ff  <= oj_in;
         a_off_ff <= offset_days;
         a_jin_ff <= day_number_in;
      end
      if (adv_b) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;
endmodule
`default_nettype wire

/* hw/rtl/gdn_queue.sv */
// Short FIFO between front and back stages.
`timescale 1ns / 1ps
`default_nettype none
module gdn_queue #(
   parameter int unsigned Depth = gdn_pkg::QueueDepth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_stall,
   input  wire gdn_pkg::work_type in_work,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output gdn_pkg::work_type      out_work
);
   localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
   gdn_pkg::work_type      mem_ff [Depth];
   logic [Aw-1:0]          wr_ff, rd_ff;
   logic [Aw:0]            cnt_ff;
   logic                   push, pop;

   assign in_stall  = (cnt_ff == (Aw+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;
   assign out_work  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == Aw'(Depth - 1)) ? '0 : wr_ff + Aw'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == Aw'(Depth - 1)) ? '0 : rd_ff + Aw'(1);
         end
         cnt_ff <= cnt_ff + (Aw+1)'(push) - (Aw+1)'(pop);
      end
      if (push) begin
         mem_ff[wr_ff] <= in_work;
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/gdn_back.sv */
// Back stage: day number to date and weekday, three pipeline steps with output register.
`timescale 1ns / 1ps
`default_nettype none
module gdn_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_stall,
   input  wire gdn_pkg::work_type in_work,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output logic [4:0]             out_day,
   output logic [3:0]             out_month,
   output logic [13:0]            out_year,
   output logic [22:0]            number_out,
   output logic [2:0]             weekday,
   output logic                   ok
);
   // constant divisions as multiply by a rounded-up reciprocal and shift
   localparam logic [25:0] Recip146097 = 26'd60207212;  // 2^43 / 146097
   localparam logic [25:0] Recip1461   = 26'd47035919;  // 2^36 / 1461
   localparam logic [23:0] Recip7      = 24'd9586981;   // 2^26 / 7
   localparam logic [11:0] Recip153    = 12'd3427;      // 2^19 / 153
   localparam logic [7:0]  Recip5      = 8'd205;        // 2^10 / 5

   logic        adv1, adv2, adv3;
   logic        v1_ff, v2_ff, v3_ff;
   logic        ok1_ff, ok2_ff, ok3_ff;
   logic [22:0] num1_ff, num2_ff, num3_ff;
   logic [2:0]  wd1_ff, wd2_ff, wd3_ff;
   logic [24:0] e1_ff;
   logic [14:0] q2_ff;
   logic [10:0] h2_ff;
   logic [4:0]  day3_ff;
   logic [3:0]  month3_ff;
   logic [13:0] year3_ff;
   // step 1: e = 4f+3 and weekday
   logic [22:0] j;
   logic [24:0] x1;
   logic [50:0] p1;
   logic [7:0]  c1;
   logic [24:0] f1;
   logic [24:0] e_in;
   logic [46:0] p7;
   logic [20:0] q7;
   logic [2:0]  wd_in;
   // step 2: year count and day of year
   logic [50:0] p2;
   logic [14:0] q_in;
   logic [10:0] r2;
   logic [10:0] h_in;
   // step 3: month, day and year
   logic [22:0] p3;
   logic [3:0]  q3;
   logic [7:0]  r3;
   logic [15:0] p5;
   logic [3:0]  mw;
   logic [4:0]  d_in;
   logic [3:0]  m_in;
   logic [13:0] y_in;

   assign adv3     = !(v3_ff && out_stall);
   assign adv2     = !(v2_ff && !adv3);
   assign adv1     = !(v1_ff && !adv2);
   assign in_stall = !adv1;

   always_comb begin
      j     = in_work.jdn[22:0];
      x1    = 25'(j) * 25'd4 + 25'd274277;
      p1    = 51'(x1) * 51'(Recip146097);
      c1    = 8'(p1 >> 43);
      f1    = 25'(j) + 25'd1401 + 25'((10'(c1) * 10'd3) >> 2) - 25'd38;
      e_in  = (f1 << 2) + 25'd3;
      p7    = 47'(j) * 47'(Recip7);
      q7    = 21'(p7 >> 26);
      wd_in = in_work.ok ? 3'(j - 23'(q7) * 23'd7) : 3'd0;
   end

   always_comb begin
      p2   = 51'(e1_ff) * 51'(Recip1461);
      q_in = 15'(p2 >> 36);
      r2   = 11'(e1_ff - 25'(q_in) * 25'd1461);
      h_in = 11'(r2 >> 2) * 11'd5 + 11'd2;
   end

   always_comb begin
      p3   = 23'(h2_ff) * 23'(Recip153);
      q3   = 4'(p3 >> 19);
      r3   = 8'(h2_ff - 11'(q3) * 11'd153);
      p5   = 16'(r3) * 16'(Recip5);
      d_in = 5'(p5 >> 10) + 5'd1;
      mw   = q3 + 4'd2;
      m_in = ((mw >= 4'd12) ? (mw - 4'd12) : mw) + 4'd1;
      y_in = 14'(q2_ff - 15'd4716 + ((m_in <= 4'd2) ? 15'd1 : 15'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
      if (adv1) begin
         ok1_ff  <= in_work.ok;
         num1_ff <= in_work.ok ? in_work.num : 23'd0;
         wd1_ff  <= wd_in;
         e1_ff   <= e_in;
      end
      if (adv2) begin
         ok2_ff  <= ok1_ff;
         num2_ff <= num1_ff;
         wd2_ff  <= wd1_ff;
         q2_ff   <= q_in;
         h2_ff   <= h_in;
      end
      if (adv3) begin
         ok3_ff    <= ok2_ff;
         num3_ff   <= num2_ff;
         wd3_ff    <= wd2_ff;
         day3_ff   <= ok2_ff ? d_in : 5'd0;
         month3_ff <= ok2_ff ? m_in : 4'd0;
         year3_ff  <= ok2_ff ? y_in : 14'd0;
      end
   end

   assign out_valid  = v3_ff;
   assign ok         = ok3_ff;
   assign number_out = num3_ff;
   assign weekday    = wd3_ff;
   assign out_day    = day3_ff;
   assign out_month  = month3_ff;
   assign out_year   = year3_ff;
endmodule
`default_nettype wire

/* verif/gregorian_day_number_unit_tb.sv */
// Testbench for the Gregorian day number unit: directed and random date beats against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module gregorian_day_number_unit_tb;

   localparam int unsigned IdleLimit = 5000;
   localparam int          FirstDay = 1721426;
   localparam int          LastDay  = 5373484;

   // One expected result beat.
   typedef struct {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [22:0] number;
      logic [2:0]  weekday;
      logic        ok;
   } date_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_action = '0;
   logic [4:0]         req_day = '0;
   logic [3:0]         req_month = '0;
   logic [13:0]        req_year = '0;
   logic signed [22:0] req_offset_days = '0;
   logic [22:0]        req_day_number_in = '0;
   logic [4:0]         req_other_day = '0;
   logic [3:0]         req_other_month = '0;
   logic [13:0]        req_other_year = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [4:0]         rsp_out_day;
   logic [3:0]         rsp_out_month;
   logic [13:0]        rsp_out_year;
   logic [22:0]        rsp_number_out;
   logic [2:0]         rsp_weekday;
   logic               rsp_ok;

   date_result_type expected_dates[$];
   int           error_count = 0;
   int           idle_cycles = 0;
   int           burst_left = 0;

   always #2 clock = ~clock;

   gregorian_day_number_unit dut (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_day, .req_month,
      .req_year, .req_offset_days, .req_day_number_in, .req_other_day,
      .req_other_month, .req_other_year, .rsp_valid, .rsp_stall, .rsp_out_day,
      .rsp_out_month, .rsp_out_year, .rsp_number_out, .rsp_weekday, .rsp_ok
   );

   // ---------------------------------------------------------------------
   // Date arithmetic for prediction, done in 64-bit integers.
   // ---------------------------------------------------------------------
   function automatic bit leap_year(longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic bit legal_date(longint d, longint m, longint y);
      longint len;
      if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1) return 1'b0;
      case (m)
         4, 6, 9, 11: len = 30;
         2:           len = leap_year(y) ? 29 : 28;
         default:     len = 31;
      endcase
      return d <= len;
   endfunction

   function automatic longint day_count(longint d, longint m, longint y);
      longint a, yy, mm;
      a  = (14 - m) / 12;
      yy = y + 4800 - a;
      mm = m + 12 * a - 3;
      return d + (153 * mm + 2) / 5 + yy * 365 + yy / 4 - yy / 100 + yy / 400 - 32045;
   endfunction

   // Predict the result beat of one request beat.
   function automatic date_result_type predict_date(logic [2:0] act, logic [4:0] d,
         logic [3:0] m, logic [13:0] y, logic signed [22:0] off, logic [22:0] jin,
         logic [4:0] od, logic [3:0] om, logic [13:0] oy);
      date_result_type r;
      bit     good;
      longint jdn, num, f, e, g, h, rm, other;
      r = '{default: '0};
      good = 1'b1;
      jdn = 0;
      num = 0;
      if (act <= gdn_pkg::ACT_DIFF) begin
         if (!legal_date(d, m, y)) good = 1'b0;
         else jdn = day_count(d, m, y);
      end else if (act == gdn_pkg::ACT_FROM_JDN) begin
         jdn = jin;
      end else begin
         good = 1'b0;
      end
      if (good) begin
         case (gdn_pkg::action_type'(act))
            gdn_pkg::ACT_TO_JDN: num = jdn;
            gdn_pkg::ACT_ADD:    jdn = jdn + longint'(off);
            gdn_pkg::ACT_SUB:    jdn = jdn - longint'(off);
            gdn_pkg::ACT_DIFF: begin
               if (!legal_date(od, om, oy)) good = 1'b0;
               else begin
                  other = day_count(od, om, oy);
                  num = jdn >= other ? jdn - other : other - jdn;
               end
            end
            default: ;
         endcase
      end
      if (good && (jdn < FirstDay || jdn > LastDay)) good = 1'b0;
      if (!good) return r;
      f = jdn + 1401 + (((4 * jdn + 274277) / 146097) * 3) / 4 - 38;
      e = 4 * f + 3;
      g = (e % 1461) / 4;
      h = 5 * g + 2;
      rm = (h / 153 + 2) % 12 + 1;
      r.day     = 5'((h % 153) / 5 + 1);
      r.month   = 4'(rm);
      r.year    = 14'(e / 1461 - 4716 + (14 - rm) / 12);
      r.number  = 23'(num);
      r.weekday = 3'(jdn % 7);
      r.ok      = 1'b1;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: hold a beat until accepted; gaps come in random bursts.
   // ---------------------------------------------------------------------
   task automatic send_date(logic [2:0] act, logic [4:0] d, logic [3:0] m,
         logic [13:0] y, logic signed [22:0] off = '0, logic [22:0] jin = '0,
         logic [4:0] od = '0, logic [3:0] om = '0, logic [13:0] oy = '0);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_action        <= act;
      req_day           <= d;
      req_month         <= m;
      req_year          <= y;
      req_offset_days   <= off;
      req_day_number_in <= jin;
      req_other_day     <= od;
      req_other_month   <= om;
      req_other_year    <= oy;
      expected_dates.push_back(predict_date(act, d, m, y, off, jin, od, om, oy));
      // advance until the beat is taken
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Receiver stall pattern: alternate calm and busy stretches.
   // ---------------------------------------------------------------------
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 200;
      if (reset || stall_phase < 60) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // Check each accepted result beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         date_result_type want;
         if (expected_dates.size() == 0) begin
            $display("%0t: unexpected result beat", $time);
            error_count++;
         end else begin
            want = expected_dates.pop_front();
            if ({rsp_out_day, rsp_out_month, rsp_out_year, rsp_number_out, rsp_weekday, rsp_ok}
                !== {want.day, want.month, want.year, want.number, want.weekday, want.ok}) begin
               $display("%0t: mismatch expected d=%0d m=%0d y=%0d n=%0d wd=%0d ok=%0d",
                        $time, want.day, want.month, want.year, want.number,
                        want.weekday, want.ok);
               $display("%0t:          actual   d=%0d m=%0d y=%0d n=%0d wd=%0d ok=%0d",
                        $time, rsp_out_day, rsp_out_month, rsp_out_year,
                        rsp_number_out, rsp_weekday, rsp_ok);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("gregorian_day_number_unit_tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test tasks
   // ---------------------------------------------------------------------
   function automatic logic [4:0] month_days(logic [3:0] m, logic [13:0] y);
      case (m)
         4, 6, 9, 11: return 5'd30;
         2:           return leap_year(y) ? 5'd29 : 5'd28;
         default:     return 5'd31;
      endcase
   endfunction

   task automatic test_directed();
      send_date(gdn_pkg::ACT_TO_JDN, 1, 1, 1);
      send_date(gdn_pkg::ACT_TO_JDN, 31, 12, 9999);
      send_date(gdn_pkg::ACT_TO_JDN, 29, 2, 2000);         // leap century
      send_date(gdn_pkg::ACT_TO_JDN, 29, 2, 1900);         // not leap
      send_date(gdn_pkg::ACT_TO_JDN, 29, 2, 2024);
      send_date(gdn_pkg::ACT_TO_JDN, 31, 4, 2024);         // day past month end
      send_date(gdn_pkg::ACT_TO_JDN, 0, 5, 2024);          // day zero
      send_date(gdn_pkg::ACT_TO_JDN, 31, 13, 2024);        // bad month
      send_date(gdn_pkg::ACT_TO_JDN, 1, 0, 2024);
      send_date(gdn_pkg::ACT_TO_JDN, 1, 1, 0);             // year zero
      send_date(gdn_pkg::ACT_TO_JDN, 31, 15, 16383);       // all bits high
      send_date(gdn_pkg::ACT_ADD, 31, 12, 9999, 23'sd1);   // past last day
      send_date(gdn_pkg::ACT_ADD, 1, 1, 1, -23'sd1);       // before first day
      send_date(gdn_pkg::ACT_ADD, 1, 1, 5000, 23'h3FFFFF);
      send_date(gdn_pkg::ACT_SUB, 1, 1, 5000, 23'h400000);
      send_date(gdn_pkg::ACT_SUB, 15, 6, 2000, -23'sd365);
      send_date(gdn_pkg::ACT_WEEKDAY, 1, 1, 2024);
      send_date(gdn_pkg::ACT_DIFF, 1, 1, 1, '0, '0, 31, 12, 9999);
      send_date(gdn_pkg::ACT_DIFF, 31, 12, 9999, '0, '0, 1, 1, 1);
      send_date(gdn_pkg::ACT_DIFF, 1, 1, 2000, '0, '0, 30, 2, 2000);  // bad second date
      send_date(gdn_pkg::ACT_FROM_JDN, 1, 1, 1, '0, 23'(FirstDay));
      send_date(gdn_pkg::ACT_FROM_JDN, 1, 1, 1, '0, 23'(LastDay));
      send_date(gdn_pkg::ACT_FROM_JDN, 1, 1, 1, '0, 23'(FirstDay - 1));
      send_date(gdn_pkg::ACT_FROM_JDN, 0, 0, 0, '0, 23'h7FFFFF);
      send_date(gdn_pkg::ACT_RSVD6, 1, 1, 2000);
      send_date(gdn_pkg::ACT_RSVD7, 1, 1, 2000);
   endtask

   task automatic test_random(int count);
      logic [2:0]  act;
      logic [3:0]  m, om;
      logic [13:0] y, oy;
      logic [4:0]  d, od;
      logic signed [22:0] off;
      logic [22:0] jin;
      repeat (count) begin
         act = 3'($urandom_range(0, 5));
         if ($urandom_range(0, 15) == 0) act = 3'($urandom);
         y  = 14'($urandom_range(1, 9999));
         m  = 4'($urandom_range(1, 12));
         d  = 5'($urandom_range(1, month_days(m, y)));
         oy = 14'($urandom_range(1, 9999));
         om = 4'($urandom_range(1, 12));
         od = 5'($urandom_range(1, month_days(om, oy)));
         off = ($urandom_range(0, 1)) ? 23'($signed($urandom_range(0, 800000)) - 400000)
                                      : 23'($urandom);
         jin = ($urandom_range(0, 7) == 0) ? 23'($urandom)
                                           : 23'($urandom_range(FirstDay, LastDay));
         // noise: raw field values, mostly illegal dates
         if ($urandom_range(0, 9) == 0) begin
            d = 5'($urandom); m = 4'($urandom); y = 14'($urandom);
         end
         if ($urandom_range(0, 9) == 0) begin
            od = 5'($urandom); om = 4'($urandom); oy = 14'($urandom);
         end
         send_date(act, d, m, y, off, jin, od, om, oy);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drop_valid();
      test_random(1950);
      drop_valid();
      // hold until every prediction is matched, then drain the pipeline
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("gregorian_day_number_unit_tb: done, clean");
      end else begin
         $display("gregorian_day_number_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* gregorian_day_number_unit.f */
hw/rtl/gdn_pkg.sv
hw/rtl/gdn_front.sv
hw/rtl/gdn_queue.sv
hw/rtl/gdn_back.sv
hw/rtl/gregorian_day_number_unit.sv
verif/gregorian_day_number_unit_tb.sv
